// ----- rtl/core/cms_pkg.sv -----
// Package for the complex magnitude sorter: transaction payload types and
// the sequencer state type. No dependencies.
package cms_pkg;

  // Input transaction: one complex item
  typedef struct packed {
    logic signed [15:0] real_in;
    logic signed [15:0] imag_in;
    logic               last_in;
  } in_t;

  // Output transaction: one item in sorted order
  typedef struct packed {
    logic signed [15:0] real_out;
    logic signed [15:0] imag_out;
    logic               last_out;
    logic               overflow;
  } out_t;

  // Sequencer states
  typedef enum logic [1:0] {
    StLoad,
    StScan,
    StEmit
  } state_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned SqW   = 31;

endpackage

// ----- rtl/core/complex_magnitude_sorter_unit.sv -----
// Loading accepts one input transaction per cycle; the item marked last starts the sort.
// Each result needs one scan of the n stored items through the item memory read port
// (n reads, a drain of the read pipeline, one emit that can stall on the output).
// A new set may load while the final result of a run still waits at the output.
// Reset clears the control state, the item count, the drop flag and the direction bit;
// the item memory content is undefined until written.
module complex_magnitude_sorter_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cms_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cms_pkg::out_t  out_data_o
);

  localparam int unsigned AddrW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ITEMS);
  localparam logic [CntW-1:0] OneCnt = CntW'(1);

  // Item memory: real in the high half, imag in the low half
  logic [cms_pkg::WordW-1:0] mem [MAX_ITEMS];

  cms_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  emit_cnt_q, emit_cnt_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic             drop_q, drop_d;
  logic             desc_q;
  logic [MAX_ITEMS-1:0] used_q, used_d;

  logic in_acc, wr_en, rd_en, emit_go, last_emit, scan_done;

  // Read pipeline
  logic [cms_pkg::WordW-1:0] rd_data_q;
  logic                      s1_vld_q;
  logic [AddrW-1:0]          s1_idx_q;
  logic                      s2_vld_q;
  logic [AddrW-1:0]          s2_idx_q;
  logic [cms_pkg::WordW-1:0] s2_word_q;
  logic [cms_pkg::SqW-1:0]   sq_re_q, sq_im_q;
  logic signed [31:0]        prod_re, prod_im;

  // Running best candidate
  logic                      best_vld_q;
  logic [AddrW-1:0]          best_idx_q;
  logic [cms_pkg::WordW-1:0] best_word_q;
  logic [cms_pkg::KeyW-1:0]  best_key_q;
  logic [cms_pkg::KeyW-1:0]  cand_key;
  logic signed [15:0]        cand_re, best_re;
  logic                      is_less, is_more, take_cand;

  logic                      out_vld_q;
  cms_pkg::out_t             out_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign wr_en     = in_acc && (count_q < MaxCnt);
  assign last_emit = (emit_cnt_q + OneCnt) == count_q;
  assign scan_done = (scan_q == count_q) && !s1_vld_q && !s2_vld_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cms_pkg::StLoad: begin
        if (in_acc && in_data_i.last_in) state_d = cms_pkg::StScan;
      end
      cms_pkg::StScan: begin
        if (scan_done) state_d = cms_pkg::StEmit;
      end
      cms_pkg::StEmit: begin
        if (emit_go) state_d = last_emit ? cms_pkg::StLoad : cms_pkg::StScan;
      end
      default: state_d = cms_pkg::StLoad;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    emit_go    = 1'b0;
    unique case (state_q)
      cms_pkg::StLoad: in_ready_o = 1'b1;
      cms_pkg::StScan: rd_en      = scan_q < count_q;
      cms_pkg::StEmit: emit_go    = !out_vld_q || out_ready_i;
      default: ;
    endcase
  end

  // Counters, drop flag and used marks
  always_comb begin
    count_d    = count_q;
    drop_d     = drop_q;
    emit_cnt_d = emit_cnt_q;
    scan_d     = scan_q;
    used_d     = used_q;
    if (wr_en) count_d = count_q + OneCnt;
    if (in_acc && !wr_en) drop_d = 1'b1;
    if (rd_en) scan_d = scan_q + OneCnt;
    if (state_d == cms_pkg::StScan && state_q != cms_pkg::StScan) scan_d = '0;
    if (emit_go) begin
      used_d[best_idx_q] = 1'b1;
      emit_cnt_d         = emit_cnt_q + OneCnt;
      if (last_emit) begin
        count_d    = '0;
        drop_d     = 1'b0;
        emit_cnt_d = '0;
        used_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cms_pkg::StLoad;
      count_q    <= '0;
      drop_q     <= 1'b0;
      emit_cnt_q <= '0;
      scan_q     <= '0;
      used_q     <= '0;
      desc_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      drop_q     <= drop_d;
      emit_cnt_q <= emit_cnt_d;
      scan_q     <= scan_d;
      used_q     <= used_d;
      if (cfg_we_i) desc_q <= cfg_data_i;
    end
  end

  // Memory write during load, read during scan; the phases never overlap
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[count_q[AddrW-1:0]] <= {in_data_i.real_in, in_data_i.imag_in};
    if (rd_en) rd_data_q <= mem[scan_q[AddrW-1:0]];
  end

  // Pipeline valid flags; skip entries already sent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= rd_en && !used_q[scan_q[AddrW-1:0]];
      s2_vld_q <= s1_vld_q;
    end
  end

  // Square both parts of the word just read
  assign prod_re = $signed(rd_data_q[31:16]) * $signed(rd_data_q[31:16]);
  assign prod_im = $signed(rd_data_q[15:0]) * $signed(rd_data_q[15:0]);

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= scan_q[AddrW-1:0];
    s2_idx_q  <= s1_idx_q;
    s2_word_q <= rd_data_q;
    sq_re_q   <= prod_re[cms_pkg::SqW-1:0];
    sq_im_q   <= prod_im[cms_pkg::SqW-1:0];
  end

  // Compare candidate with best; key ties go by real part, strict order keeps earliest
  assign cand_key  = {1'b0, sq_re_q} + {1'b0, sq_im_q};
  assign cand_re   = s2_word_q[31:16];
  assign best_re   = best_word_q[31:16];
  assign is_less   = (cand_key < best_key_q) || (cand_key == best_key_q && cand_re < best_re);
  assign is_more   = (cand_key > best_key_q) || (cand_key == best_key_q && cand_re > best_re);
  assign take_cand = s2_vld_q && (!best_vld_q || (desc_q ? is_more : is_less));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
    end else if (state_q != cms_pkg::StScan) begin
      best_vld_q <= 1'b0;
    end else if (take_cand) begin
      best_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_cand) begin
      best_idx_q  <= s2_idx_q;
      best_word_q <= s2_word_q;
      best_key_q  <= cand_key;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_go) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q.real_out <= best_word_q[31:16];
      out_q.imag_out <= best_word_q[15:0];
      out_q.last_out <= last_emit;
      out_q.overflow <= drop_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/cms_checker.sv -----
// Port-level checker for the complex magnitude sorter, bound to complex_magnitude_sorter_unit.
// Depends on cms_pkg for the payload types.
module cms_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input cms_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cms_pkg::out_t out_data_o
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // Stop loading once the last item of a set is taken
  a_last_stops_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_in |=> !in_ready_o)
    else $error("input accepted during sort");

  // Keep the input closed while a run is still being sent
  a_run_blocks_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_out |-> !in_ready_o)
    else $error("input ready in the middle of a run");

  // Keep the overflow flag constant within one run
  a_overflow_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last_out) ##1 out_valid_o |->
    out_data_o.overflow == $past(out_data_o.overflow))
    else $error("overflow changed within a run");

endmodule

bind complex_magnitude_sorter_unit cms_checker u_cms_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
